>>> design/drs_pkg.sv
`timescale 1ns / 1ps

package drs_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int TOKEN_WIDTH_DEF = 32;

    localparam int OP_W        = 2;
    localparam int TOK_IO_W    = 32;
    localparam int POS_W       = 6;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_SHUFFLE = 2'd1,
        OP_REVERSE = 2'd2,
        OP_DUMP    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_FETCH,
        ST_DISPATCH,
        ST_APPEND,
        ST_ERROR,
        ST_GATHER,
        ST_GDRAIN,
        ST_SCATTER,
        ST_SDRAIN,
        ST_EMIT
    } step_t;

    typedef enum logic [2:0] {
        J_ACCEPT,
        J_DISPATCH,
        J_GOTO,
        J_LOOP,
        J_HOLD
    } jmp_t;

    typedef struct packed {
        logic  in_rdy;
        logic  gather;
        logic  scatter;
        logic  emit;
        logic  append;
        logic  err;
        logic  lim_cnt;
        jmp_t  jmp;
        step_t tgt;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        op_t  op;
        logic full;
        logic range_ok;
        logic count_zero;
        logic rd_busy;
        logic slot_free;
        logic emit_ok;
    } stat_t;

    function automatic ctrl_t ucode(input step_t st);
        ctrl_t cw;
        cw     = '0;
        cw.jmp = J_GOTO;
        cw.tgt = ST_FETCH;
        unique case (st)
            ST_FETCH:
            begin
                cw.in_rdy = 1'b1;
                cw.jmp    = J_ACCEPT;
                cw.tgt    = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                cw.jmp = J_DISPATCH;
            end
            ST_APPEND:
            begin
                cw.append = 1'b1;
            end
            ST_ERROR:
            begin
                cw.err = 1'b1;
                cw.jmp = J_HOLD;
            end
            ST_GATHER:
            begin
                cw.gather = 1'b1;
                cw.jmp    = J_LOOP;
                cw.tgt    = ST_GDRAIN;
            end
            ST_GDRAIN:
            begin
                cw.tgt = ST_SCATTER;
            end
            ST_SCATTER:
            begin
                cw.scatter = 1'b1;
                cw.jmp     = J_LOOP;
                cw.tgt     = ST_SDRAIN;
            end
            ST_SDRAIN:
            begin
                cw.lim_cnt = 1'b1;
                cw.tgt     = ST_EMIT;
            end
            ST_EMIT:
            begin
                cw.emit = 1'b1;
                cw.jmp  = J_LOOP;
            end
            default:
            begin
                cw.tgt = ST_FETCH;
            end
        endcase
        return cw;
    endfunction

endpackage

>>> design/drs_seq.sv
`timescale 1ns / 1ps

module drs_seq #(
    parameter int DEPTH = drs_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  drs_pkg::stat_t               stat,
    input  logic [$clog2(DEPTH)-1:0]     lim_range,
    input  logic [$clog2(DEPTH)-1:0]     lim_count,
    output drs_pkg::ctrl_t               cw,
    output logic [$clog2(DEPTH)-1:0]     idx,
    output logic                         at_lim
);
    import drs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    step_t           step_reg, step_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   lim_reg, lim_next;
    logic            fire;

    assign cw     = ucode(step_reg);
    assign idx    = idx_reg;
    assign at_lim = (idx_reg == lim_reg);
    assign fire   = !cw.emit || stat.emit_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_FETCH;
            idx_reg  <= '0;
            lim_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            idx_reg  <= idx_next;
            lim_reg  <= lim_next;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        idx_next  = idx_reg;
        lim_next  = lim_reg;
        unique case (cw.jmp)
            J_ACCEPT:
            begin
                if (stat.accept)
                begin
                    step_next = cw.tgt;
                    idx_next  = '0;
                end
            end
            J_DISPATCH:
            begin
                if (!stat.rd_busy)
                begin
                    lim_next = (stat.op == OP_DUMP) ? lim_count : lim_range;
                    unique case (stat.op)
                        OP_APPEND:
                            step_next = stat.full ? ST_ERROR : ST_APPEND;
                        OP_SHUFFLE, OP_REVERSE:
                            step_next = stat.range_ok ? ST_GATHER : ST_ERROR;
                        OP_DUMP:
                            step_next = stat.count_zero ? ST_FETCH : ST_EMIT;
                        default:
                            step_next = ST_FETCH;
                    endcase
                end
            end
            J_GOTO:
            begin
                step_next = cw.tgt;
                if (cw.lim_cnt)
                begin
                    lim_next = lim_count;
                end
            end
            J_LOOP:
            begin
                if (fire)
                begin
                    if (at_lim)
                    begin
                        step_next = cw.tgt;
                        idx_next  = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            J_HOLD:
            begin
                if (stat.slot_free)
                begin
                    step_next = cw.tgt;
                end
            end
            default:
            begin
                step_next = ST_FETCH;
            end
        endcase
    end

    a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.jmp == J_LOOP) |-> (idx_reg <= lim_reg))
        else $error("loop index beyond limit");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        stat.accept |=> (step_reg == ST_DISPATCH))
        else $error("accepted beat not dispatched");

    a_gather_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((step_reg == ST_GATHER) && at_lim) |=> (step_reg == ST_GDRAIN))
        else $error("gather pass did not end");

endmodule

>>> design/deck_range_shuffle_reverse_unit.sv
`timescale 1ns / 1ps
// channel  direction  tdata (low bit up)                               tuser   tlast
// s_axis   in         token_in[31:0] range_start[5:0] range_end[5:0]   op      -
// m_axis   out        token_out[31:0] position[5:0]                    error   last
//
// append writes one card; dump runs the emit pass; shuffle or reverse runs a gather pass,
// a scatter pass and the emit pass over a range, with a single read port on the card store
// (one entry a cycle in each pass, the emit pass only while the output register can move)
// reset clears count and valid flags; store contents stay undefined, no clearing pass
// a low m_axis_tready stalls the emit pass; the final beat may wait in the output
// register while the next input beat is taken

module deck_range_shuffle_reverse_unit #(
    parameter int DEPTH       = drs_pkg::DEPTH_DEF,
    parameter int TOKEN_WIDTH = drs_pkg::TOKEN_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [drs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // token_in, range_start, range_end
    input  logic [drs_pkg::OP_W-1:0]           s_axis_tuser,  // op
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [drs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // token_out, position
    output logic                               m_axis_tuser,  // error
    output logic                               m_axis_tlast
);
    import drs_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int OPAD = OUT_TDATA_W - TOK_IO_W - POS_W;

    ctrl_t                  cw;
    stat_t                  stat;
    logic [AW-1:0]          idx;
    logic                   at_lim;
    logic [AW-1:0]          lim_range;
    logic [AW-1:0]          lim_count;

    logic                   accept;
    op_t                    op_reg;
    logic [TOKEN_WIDTH-1:0] tok_reg;
    logic [POS_W-1:0]       s_reg;
    logic [POS_W-1:0]       e_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [TOKEN_WIDTH+TOK_IO_W-1:0] tok_in_wide;
    logic [TOKEN_WIDTH+TOK_IO_W-1:0] tok_out_wide;

    logic [TOKEN_WIDTH-1:0] store_mem [DEPTH];
    logic [TOKEN_WIDTH-1:0] scratch_mem [DEPTH];
    logic [TOKEN_WIDTH-1:0] store_q_reg;
    logic [TOKEN_WIDTH-1:0] scratch_q_reg;

    logic                   st_re, st_we, sc_we;
    logic [AW-1:0]          st_raddr, st_waddr;
    logic [TOKEN_WIDTH-1:0] st_wdata;

    logic                   wb_valid_reg, wb_valid_next;
    logic                   wb_store_reg;
    logic [AW-1:0]          wb_addr_reg;

    logic                   rv_reg, rv_next;
    logic [AW-1:0]          rv_idx_reg;
    logic                   rv_last_reg;
    logic                   ov_reg, ov_next;
    logic [TOK_IO_W-1:0]    o_tok_reg;
    logic [POS_W-1:0]       o_pos_reg;
    logic                   o_last_reg;
    logic                   o_err_reg;

    logic                   slot_free, rv_move, issue, load_err;
    logic [POS_W-1:0]       idx6, lim6, take6, src6;
    logic [POS_W:0]         n7;

    // sequencer
    drs_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .lim_range (lim_range),
        .lim_count (lim_count),
        .cw        (cw),
        .idx       (idx),
        .at_lim    (at_lim)
    );

    assign s_axis_tready = cw.in_rdy;
    assign accept        = cw.in_rdy && s_axis_tvalid;

    assign tok_in_wide  = {{TOKEN_WIDTH{1'b0}}, s_axis_tdata[TOK_IO_W-1:0]};
    assign tok_out_wide = {{TOK_IO_W{1'b0}}, store_q_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(s_axis_tuser);
            tok_reg <= tok_in_wide[TOKEN_WIDTH-1:0];
            s_reg   <= s_axis_tdata[TOK_IO_W+POS_W-1:TOK_IO_W];
            e_reg   <= s_axis_tdata[TOK_IO_W+2*POS_W-1:TOK_IO_W+POS_W];
        end
    end

    // range address generation
    assign idx6  = POS_W'(idx);
    assign lim6  = e_reg - s_reg;
    assign n7    = {1'b0, lim6} + (POS_W+1)'(1);
    assign take6 = n7[POS_W:1];

    always_comb
    begin
        if (op_reg == OP_REVERSE)
        begin
            src6 = e_reg - idx6;
        end
        else if (idx6[0])
        begin
            src6 = s_reg + take6 + (idx6 >> 1);
        end
        else if (n7[0] && (idx6 == lim6))
        begin
            src6 = e_reg;
        end
        else
        begin
            src6 = s_reg + (idx6 >> 1);
        end
    end

    assign lim_range = AW'(lim6);
    assign lim_count = AW'(count_reg - CW'(1));

    // status to sequencer
    assign slot_free = !ov_reg || m_axis_tready;
    assign rv_move   = rv_reg && slot_free;
    assign issue     = cw.emit && (!rv_reg || rv_move);
    assign load_err  = cw.err && slot_free;

    always_comb
    begin
        stat            = '0;
        stat.accept     = accept;
        stat.op         = op_reg;
        stat.full       = (count_reg == CW'(DEPTH));
        stat.range_ok   = (s_reg <= e_reg) && ({1'b0, e_reg} < (POS_W+1)'(count_reg));
        stat.count_zero = (count_reg == '0);
        stat.rd_busy    = rv_reg;
        stat.slot_free  = slot_free;
        stat.emit_ok    = !rv_reg || rv_move;
    end

    // card store and scratch buffer
    assign st_re    = cw.gather || issue;
    assign st_raddr = cw.gather ? AW'(src6) : idx;
    assign st_we    = (wb_valid_reg && wb_store_reg) || cw.append;
    assign st_waddr = cw.append ? AW'(count_reg) : wb_addr_reg;
    assign st_wdata = cw.append ? tok_reg : scratch_q_reg;
    assign sc_we    = wb_valid_reg && !wb_store_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        if (st_re)
        begin
            store_q_reg <= store_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            scratch_mem[wb_addr_reg] <= store_q_reg;
        end
        if (cw.scatter)
        begin
            scratch_q_reg <= scratch_mem[idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.gather || cw.scatter)
        begin
            wb_store_reg <= cw.scatter;
            wb_addr_reg  <= cw.scatter ? AW'(s_reg + idx6) : idx;
        end
        if (issue)
        begin
            rv_idx_reg  <= idx;
            rv_last_reg <= at_lim;
        end
        if (rv_move)
        begin
            o_tok_reg  <= tok_out_wide[TOK_IO_W-1:0];
            o_pos_reg  <= POS_W'(rv_idx_reg);
            o_last_reg <= rv_last_reg;
            o_err_reg  <= 1'b0;
        end
        else if (load_err)
        begin
            o_tok_reg  <= '0;
            o_pos_reg  <= '0;
            o_last_reg <= 1'b1;
            o_err_reg  <= 1'b1;
        end
    end

    always_comb
    begin
        count_next    = cw.append ? count_reg + CW'(1) : count_reg;
        wb_valid_next = cw.gather || cw.scatter;
        rv_next       = issue ? 1'b1 : (rv_move ? 1'b0 : rv_reg);
        if (rv_move || load_err)
        begin
            ov_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            wb_valid_reg <= 1'b0;
            rv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            wb_valid_reg <= wb_valid_next;
            rv_reg       <= rv_next;
            ov_reg       <= ov_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {{OPAD{1'b0}}, o_pos_reg, o_tok_reg};
    assign m_axis_tuser  = o_err_reg;
    assign m_axis_tlast  = o_last_reg;

    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cw.append && wb_valid_reg && wb_store_reg))
        else $error("store write port claimed twice");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("card count beyond depth");

    a_err_order: assert property (@(posedge clk) disable iff (!rst_n)
        load_err |-> !rv_reg)
        else $error("error beat overtakes a pending read");

endmodule

>>> sim/deck_range_shuffle_reverse_unit_tb.sv
`timescale 1ns / 1ps

module deck_range_shuffle_reverse_unit_tb;

    import drs_pkg::*;

    localparam int CARD_SLOTS = DEPTH_DEF;
    localparam int DRAIN_CYCLES = 4 * CARD_SLOTS + 16;

    typedef struct packed {
        logic [31:0] token;
        logic [5:0]  pos;
        logic        last;
        logic        err;
    } card_beat_t;

    class deck_tracker;
        logic [31:0] cards[CARD_SLOTS];
        int unsigned card_total;
        card_beat_t  expected_beats[$];
        int unsigned mismatches;

        function new();
            card_total = 0;
            mismatches = 0;
        endfunction

        function void take_command(op_t op, logic [31:0] tok, logic [5:0] s, logic [5:0] e);
            logic [31:0] held[CARD_SLOTS];
            card_beat_t  b;
            int unsigned n;
            int unsigned half;
            int unsigned w;
            int unsigned lo;
            int unsigned hi;
            logic [31:0] t;
            b = '0;
            b.last = 1'b1;
            b.err = 1'b1;
            if (op == OP_APPEND)
            begin
                if (card_total >= CARD_SLOTS)
                    expected_beats.insert(expected_beats.size(), b);
                else
                begin
                    cards[card_total] = tok;
                    card_total++;
                end
            end
            else if (op != OP_DUMP && (s > e || 32'(e) >= card_total))
                expected_beats.insert(expected_beats.size(), b);
            else
            begin
                if (op == OP_SHUFFLE)
                begin
                    n = 32'(e) - 32'(s) + 1;
                    half = n / 2;
                    w = 0;
                    for (int unsigned i = 0; i < half; i++)
                    begin
                        held[w] = cards[s + i];
                        held[w + 1] = cards[s + half + i];
                        w += 2;
                    end
                    if (n % 2 == 1)
                    begin
                        held[w] = cards[e];
                        w++;
                    end
                    for (int unsigned i = 0; i < w; i++)
                        cards[s + i] = held[i];
                end
                else if (op == OP_REVERSE)
                begin
                    lo = 32'(s);
                    hi = 32'(e);
                    while (lo < hi)
                    begin
                        t = cards[lo];
                        cards[lo] = cards[hi];
                        cards[hi] = t;
                        lo++;
                        hi--;
                    end
                end
                for (int unsigned i = 0; i < card_total; i++)
                begin
                    b.token = cards[i];
                    b.pos = i[5:0];
                    b.last = (i + 1 == card_total);
                    b.err = 1'b0;
                    expected_beats.insert(expected_beats.size(), b);
                end
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_beat(logic [31:0] tok, logic [5:0] pos, logic last, logic err);
            card_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual token %h pos %0d last %b err %b",
                         $time, tok, pos, last, err);
                mismatches++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (tok !== want.token)
                    report("token_out", want.token, tok);
                if (pos !== want.pos)
                    report("position", 32'(want.pos), 32'(pos));
                if (last !== want.last)
                    report("last", 32'(want.last), 32'(last));
                if (err !== want.err)
                    report("error", 32'(want.err), 32'(err));
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    deck_tracker deck;
    int unsigned burst_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_run = 0;
    int unsigned stall_phase = 0;

    deck_range_shuffle_reverse_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stall pattern, picks a new random mode at the end of each random run
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_run <= $urandom_range(16, 96);
        end
        else
            stall_run <= stall_run - 1;
        case (stall_mode)
            0:
                m_axis_tready <= 1'b1;
            1:
                m_axis_tready <= 1'($urandom_range(0, 1));
            2:
                m_axis_tready <= (stall_phase % 4 != 0);
            default:
                m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            deck.check_beat(m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast, m_axis_tuser);
    end

    task automatic send_command(input op_t op, input logic [31:0] tok,
                                input logic [5:0] s, input logic [5:0] e);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, e, s, tok};
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        deck.take_command(op, tok, s, e);
        burst_left--;
    endtask

    task automatic issue_random_command();
        op_t         op;
        logic [31:0] tok;
        logic [5:0]  s;
        logic [5:0]  e;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        tok = $urandom();
        s = 6'($urandom_range(0, 63));
        e = 6'($urandom_range(0, 63));
        if ((deck.card_total < CARD_SLOTS && pick < 45) || pick < 6)
            op = OP_APPEND;
        else
        begin
            op = op_t'($urandom_range(1, 3));
            if (deck.card_total != 0 && $urandom_range(0, 9) < 8)
            begin
                s = 6'($urandom_range(0, deck.card_total - 1));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    e = s;
                else if (pick == 1)
                begin
                    s = 6'd0;
                    e = 6'(deck.card_total - 1);
                end
                else
                    e = 6'($urandom_range(32'(s), deck.card_total - 1));
            end
            else if (deck.card_total < CARD_SLOTS && $urandom_range(0, 1) == 1)
                e = 6'($urandom_range(deck.card_total, 63));
            else
            begin
                e = 6'($urandom_range(0, 62));
                s = 6'($urandom_range(32'(e) + 1, 63));
            end
        end
        send_command(op, tok, s, e);
    endtask

    initial
    begin
        deck = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_APPEND;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store
        send_command(OP_DUMP, 32'h0, 6'd0, 6'd0);
        send_command(OP_SHUFFLE, 32'h0, 6'd0, 6'd0);
        send_command(OP_REVERSE, 32'hFFFF_FFFF, 6'd0, 6'd0);

        send_command(OP_APPEND, 32'h0000_0000, 6'd63, 6'd63);
        send_command(OP_APPEND, 32'hFFFF_FFFF, 6'd0, 6'd0);
        send_command(OP_APPEND, 32'hAAAA_AAAA, 6'd21, 6'd42);
        send_command(OP_APPEND, 32'h5555_5555, 6'd42, 6'd21);
        send_command(OP_APPEND, 32'h8000_0001, 6'd0, 6'd63);
        send_command(OP_APPEND, 32'h1234_5678, 6'd63, 6'd0);
        send_command(OP_APPEND, 32'h7FFF_FFFE, 6'd5, 6'd5);
        send_command(OP_DUMP, 32'hFFFF_FFFF, 6'd63, 6'd63);

        // even and odd ranges, whole store and inner spans
        send_command(OP_SHUFFLE, 32'h0, 6'd0, 6'd5);
        send_command(OP_SHUFFLE, 32'h0, 6'd1, 6'd5);
        send_command(OP_SHUFFLE, 32'h0, 6'd0, 6'd6);
        send_command(OP_REVERSE, 32'h0, 6'd0, 6'd6);
        send_command(OP_REVERSE, 32'h0, 6'd1, 6'd4);

        // single-card ranges
        send_command(OP_REVERSE, 32'h0, 6'd2, 6'd2);
        send_command(OP_SHUFFLE, 32'h0, 6'd6, 6'd6);

        // bad ranges
        send_command(OP_REVERSE, 32'h0, 6'd4, 6'd1);
        send_command(OP_SHUFFLE, 32'h0, 6'd0, 6'd7);
        send_command(OP_SHUFFLE, 32'h0, 6'd63, 6'd63);
        send_command(OP_REVERSE, 32'h0, 6'd0, 6'd63);
        send_command(OP_SHUFFLE, 32'h0, 6'd63, 6'd0);

        repeat (290) issue_random_command();

        s_axis_tvalid <= 1'b0;
        while (deck.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (deck.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
